FILE: rtl/core/particle_surface_scalar_field_defines.svh
// Assertion macros shared by the particle surface scalar field RTL.
`ifndef PARTICLE_SURFACE_SCALAR_FIELD_DEFINES_SVH
`define PARTICLE_SURFACE_SCALAR_FIELD_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define PSF_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define PSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/psf_pkg.sv
// Shared constants, register codes and types of the particle surface scalar field.
`timescale 1ns / 1ps
package psf_pkg;
	localparam int MAX_PARTICLES = 256;
	localparam int FRAC_BITS     = 16;
	localparam int COORD_W       = 32;
	localparam int CFG_W         = 31;
	localparam int NUM_AXES      = 3;
	localparam int ACC_W         = 64;
	localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
	localparam int T_W           = FRAC_BITS + 1;
	localparam int WT_W          = FRAC_BITS + $clog2(MAX_PARTICLES) + 1;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int TDATA_W       = NUM_AXES * 2 * COORD_W;
	localparam int ITER_W        = $clog2(ACC_W);
	localparam int SQRT_STEPS    = ACC_W / 2;

	localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(1) << FRAC_BITS;

	// Configuration register indexes.
	localparam logic REG_KERNEL_RADIUS   = 1'b0;
	localparam logic REG_PARTICLE_RADIUS = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] kernel_radius;
		logic [CFG_W-1:0] particle_radius;
	} psf_cfg_t;

	// One classified word as it waits between front and back.
	typedef struct packed {
		logic signed [COORD_W-1:0] vx;
		logic signed [COORD_W-1:0] vy;
		logic signed [COORD_W-1:0] vz;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic [CFG_W-1:0]          ax;
		logic [CFG_W-1:0]          ay;
		logic [CFG_W-1:0]          az;
		logic                      acc;
		logic                      far;
		logic                      last;
	} psf_item_t;
endpackage

FILE: rtl/core/psf_front.sv
// Front end: accepts input words, counts particles and classifies each word.
`timescale 1ns / 1ps
module psf_front import psf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  psf_cfg_t           cfg,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,
	input  logic               s_axis_tuser,
	input  logic               s_axis_tlast,
	input  logic               q_full,
	output logic               push,
	output psf_item_t          item
);
	logic [CNT_W-1:0]          cnt_q;
	logic signed [COORD_W-1:0] vtx [NUM_AXES];
	logic signed [COORD_W-1:0] par [NUM_AXES];
	logic signed [COORD_W:0]   diff [NUM_AXES];
	logic [COORD_W:0]          dmag [NUM_AXES];
	logic [NUM_AXES-1:0]       axis_far;
	logic                      acc;

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign acc           = s_axis_tuser && (cnt_q < CNT_W'(MAX_PARTICLES));

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			vtx[i]      = s_axis_tdata[COORD_W*i +: COORD_W];
			par[i]      = s_axis_tdata[COORD_W*(i+NUM_AXES) +: COORD_W];
			diff[i]     = {vtx[i][COORD_W-1], vtx[i]} - {par[i][COORD_W-1], par[i]};
			dmag[i]     = diff[i][COORD_W] ? (COORD_W+1)'(-diff[i]) : (COORD_W+1)'(diff[i]);
			axis_far[i] = dmag[i] >= (COORD_W+1)'(cfg.kernel_radius);
		end
	end

	always_comb begin
		item.vx   = vtx[0];
		item.vy   = vtx[1];
		item.vz   = vtx[2];
		item.px   = par[0];
		item.py   = par[1];
		item.pz   = par[2];
		item.ax   = dmag[0][CFG_W-1:0];
		item.ay   = dmag[1][CFG_W-1:0];
		item.az   = dmag[2][CFG_W-1:0];
		item.acc  = acc;
		item.far  = |axis_far;
		item.last = s_axis_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (s_axis_tlast) begin
				cnt_q <= '0;
			end else if (acc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end
endmodule

FILE: rtl/core/psf_queue.sv
// Short queue of classified words between front and back.
`timescale 1ns / 1ps
module psf_queue import psf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  psf_item_t item_in,
	input  logic      pop,
	output logic      valid,
	output psf_item_t item_out,
	output logic      full
);
	psf_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign valid    = cnt_q != '0;
	assign full     = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign item_out = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end
endmodule

FILE: rtl/core/psf_back.sv
// Back end: kernel weights, accumulation, mean division, square root and result register.
`timescale 1ns / 1ps
`include "particle_surface_scalar_field_defines.svh"
module psf_back import psf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  psf_cfg_t           cfg,
	input  logic               q_valid,
	input  psf_item_t          q_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] out_value,
	output logic               out_empty
);
	typedef enum logic [4:0] {
		S_IDLE, S_SQX, S_SQY, S_SQZ, S_SQR, S_TCHK, S_TDIV, S_TT, S_T3, S_KW,
		S_PX, S_PY, S_PZ, S_PACC, S_FIN, S_DIV, S_MEAN, S_DIFF, S_MX, S_MY,
		S_MZ, S_MACC, S_SQRT, S_PHI, S_OUT
	} state_t;

	state_t                    state_q;
	psf_item_t                 item_q;
	logic [ACC_W-1:0]          mul_q;
	logic [COORD_W-1:0]        mul_a;
	logic [COORD_W-1:0]        mul_b;
	logic [ACC_W-1:0]          d2_q;
	logic [ACC_W-1:0]          r2_q;
	logic [ACC_W-1:0]          rem_q;
	logic [ACC_W-1:0]          root_q;
	logic [ACC_W-1:0]          bit_q;
	logic [T_W-1:0]            t_q;
	logic [T_W-1:0]            k_q;
	logic [ITER_W-1:0]         cnt_q;
	logic signed [ACC_W-1:0]   sum_q [NUM_AXES];
	logic [NUM_AXES-1:0]       neg_q;
	logic [WT_W-1:0]           drem_q [NUM_AXES];
	logic [WT_W-1:0]           w_q;
	logic [COORD_W-1:0]        a_q [NUM_AXES];
	logic [COORD_W-1:0]        value_q;
	logic                      empty_q;
	logic                      out_valid_q;
	logic [COORD_W-1:0]        out_value_q;
	logic                      out_empty_q;

	logic signed [COORD_W-1:0] vtx [NUM_AXES];
	logic signed [COORD_W-1:0] par [NUM_AXES];
	logic [COORD_W-1:0]        pmag [NUM_AXES];
	logic [WT_W:0]             trial [NUM_AXES];
	logic [NUM_AXES-1:0]       qbit;
	logic signed [COORD_W+1:0] mean [NUM_AXES];
	logic signed [COORD_W+2:0] mdiff [NUM_AXES];
	logic [COORD_W+2:0]        mmag [NUM_AXES];
	logic signed [ACC_W-1:0]   term;
	logic [ACC_W-1:0]          rem2;
	logic [ACC_W-1:0]          sq_try;
	logic signed [COORD_W+1:0] phi;
	logic                      out_free;

	assign pop       = (state_q == S_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_empty = out_empty_q;
	assign out_free  = !out_valid_q || out_ready;

	assign vtx[0] = item_q.vx;
	assign vtx[1] = item_q.vy;
	assign vtx[2] = item_q.vz;
	assign par[0] = item_q.px;
	assign par[1] = item_q.py;
	assign par[2] = item_q.pz;

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			pmag[i]  = par[i][COORD_W-1] ? COORD_W'(-par[i]) : COORD_W'(par[i]);
			trial[i] = {drem_q[i], sum_q[i][ACC_W-1]};
			qbit[i]  = trial[i] >= {1'b0, w_q};
			mean[i]  = sum_q[i][COORD_W+1:0];
			mdiff[i] = {{3{vtx[i][COORD_W-1]}}, vtx[i]} - {mean[i][COORD_W+1], mean[i]};
			mmag[i]  = mdiff[i][COORD_W+2] ? (COORD_W+3)'(-mdiff[i])
				: (COORD_W+3)'(mdiff[i]);
		end
	end

	// Shared multiplier operand select.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQX: begin
				mul_a = COORD_W'(item_q.ax);
				mul_b = COORD_W'(item_q.ax);
			end
			S_SQY: begin
				mul_a = COORD_W'(item_q.ay);
				mul_b = COORD_W'(item_q.ay);
			end
			S_SQZ: begin
				mul_a = COORD_W'(item_q.az);
				mul_b = COORD_W'(item_q.az);
			end
			S_SQR: begin
				mul_a = COORD_W'(cfg.kernel_radius);
				mul_b = COORD_W'(cfg.kernel_radius);
			end
			S_TT: begin
				mul_a = COORD_W'(t_q);
				mul_b = COORD_W'(t_q);
			end
			S_T3: begin
				mul_a = COORD_W'(mul_q[FRAC_BITS +: T_W]);
				mul_b = COORD_W'(t_q);
			end
			S_PX: begin
				mul_a = pmag[0];
				mul_b = COORD_W'(k_q);
			end
			S_PY: begin
				mul_a = pmag[1];
				mul_b = COORD_W'(k_q);
			end
			S_PZ: begin
				mul_a = pmag[2];
				mul_b = COORD_W'(k_q);
			end
			S_MX: begin
				mul_a = a_q[0];
				mul_b = a_q[0];
			end
			S_MY: begin
				mul_a = a_q[1];
				mul_b = a_q[1];
			end
			S_MZ: begin
				mul_a = a_q[2];
				mul_b = a_q[2];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		term = $signed(mul_q);
		unique case (state_q)
			S_PY:    term = par[0][COORD_W-1] ? -$signed(mul_q) : $signed(mul_q);
			S_PZ:    term = par[1][COORD_W-1] ? -$signed(mul_q) : $signed(mul_q);
			S_PACC:  term = par[2][COORD_W-1] ? -$signed(mul_q) : $signed(mul_q);
			default: term = $signed(mul_q);
		endcase
	end

	assign rem2   = rem_q << 1;
	assign sq_try = root_q + bit_q;
	assign phi    = $signed({2'b00, root_q[COORD_W-1:0]})
		- $signed({3'b000, cfg.particle_radius});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			w_q         <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			mul_q <= ACC_W'(mul_a) * ACC_W'(mul_b);
			// In S_OUT a free output register is reloaded below instead.
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						if (q_item.acc && !q_item.far) begin
							state_q <= S_SQX;
						end else if (q_item.last) begin
							state_q <= S_FIN;
						end
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin
					d2_q    <= mul_q;
					state_q <= S_SQZ;
				end
				S_SQZ: begin
					d2_q    <= d2_q + mul_q;
					state_q <= S_SQR;
				end
				S_SQR: begin
					d2_q    <= d2_q + mul_q;
					state_q <= S_TCHK;
				end
				S_TCHK: begin
					r2_q <= mul_q;
					priority if (d2_q >= mul_q) begin
						k_q     <= '0;
						state_q <= S_PX;
					end else if (d2_q == '0) begin
						t_q     <= T_W'(ONE_Q);
						state_q <= S_TT;
					end else begin
						rem_q   <= mul_q - d2_q;
						t_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_TDIV;
					end
				end
				S_TDIV: begin
					if (rem2 >= r2_q) begin
						rem_q <= rem2 - r2_q;
						t_q   <= {t_q[T_W-2:0], 1'b1};
					end else begin
						rem_q <= rem2;
						t_q   <= {t_q[T_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + ITER_W'(1);
					if (cnt_q == ITER_W'(FRAC_BITS - 1)) begin
						state_q <= S_TT;
					end
				end
				S_TT: state_q <= S_T3;
				S_T3: state_q <= S_KW;
				S_KW: begin
					k_q     <= mul_q[FRAC_BITS +: T_W];
					state_q <= S_PX;
				end
				S_PX: state_q <= S_PY;
				S_PY: begin
					sum_q[0] <= sum_q[0] + term;
					state_q  <= S_PZ;
				end
				S_PZ: begin
					sum_q[1] <= sum_q[1] + term;
					state_q  <= S_PACC;
				end
				S_PACC: begin
					sum_q[2] <= sum_q[2] + term;
					w_q      <= w_q + WT_W'(k_q);
					state_q  <= item_q.last ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (w_q == '0) begin
						value_q <= ONE_Q;
						empty_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						for (int i = 0; i < NUM_AXES; i++) begin
							neg_q[i]  <= sum_q[i][ACC_W-1];
							sum_q[i]  <= sum_q[i][ACC_W-1] ? -sum_q[i] : sum_q[i];
							drem_q[i] <= '0;
						end
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					for (int i = 0; i < NUM_AXES; i++) begin
						drem_q[i] <= qbit[i] ? WT_W'(trial[i] - {1'b0, w_q})
							: WT_W'(trial[i]);
						sum_q[i]  <= {sum_q[i][ACC_W-2:0], qbit[i]};
					end
					cnt_q <= cnt_q + ITER_W'(1);
					if (cnt_q == ITER_W'(ACC_W - 1)) begin
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					// The mean magnitude never exceeds 2^31, so 33 quotient bits suffice.
					for (int i = 0; i < NUM_AXES; i++) begin
						sum_q[i] <= neg_q[i] ? -ACC_W'({1'b0, sum_q[i][COORD_W:0]})
							: ACC_W'({1'b0, sum_q[i][COORD_W:0]});
					end
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					for (int i = 0; i < NUM_AXES; i++) begin
						a_q[i] <= (mmag[i] > (COORD_W+3)'(ONE_Q << (COORD_W-1-FRAC_BITS)))
							? COORD_W'(ONE_Q << (COORD_W-1-FRAC_BITS))
							: mmag[i][COORD_W-1:0];
					end
					state_q <= S_MX;
				end
				S_MX: state_q <= S_MY;
				S_MY: begin
					d2_q    <= mul_q;
					state_q <= S_MZ;
				end
				S_MZ: begin
					d2_q    <= d2_q + mul_q;
					state_q <= S_MACC;
				end
				S_MACC: begin
					rem_q   <= d2_q + mul_q;
					root_q  <= '0;
					bit_q   <= ACC_W'(1) << (ACC_W - 2);
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (rem_q >= sq_try) begin
						rem_q  <= rem_q - sq_try;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + ITER_W'(1);
					if (cnt_q == ITER_W'(SQRT_STEPS - 1)) begin
						state_q <= S_PHI;
					end
				end
				S_PHI: begin
					value_q <= (phi > $signed((COORD_W+2)'({1'b0, {(COORD_W-1){1'b1}}})))
						? {1'b0, {(COORD_W-1){1'b1}}} : phi[COORD_W-1:0];
					empty_q <= 1'b0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= value_q;
						out_empty_q <= empty_q;
						w_q         <= '0;
						for (int i = 0; i < NUM_AXES; i++) begin
							sum_q[i] <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PSF_ASSERT(a_div_weight, state_q == S_DIV, w_q != '0, "mean division with zero weight")
	`PSF_ASSERT(a_empty_one, out_valid_q && out_empty_q, out_value_q == ONE_Q, "empty not one")
	`PSF_ASSERT_NEXT(a_hold_result, state_q == S_OUT && !out_free, state_q == S_OUT, "lost result")
endmodule

FILE: rtl/core/particle_surface_scalar_field.sv
// Top level of the particle surface scalar field block.
`timescale 1ns / 1ps
// Particle surface scalar field. Each input word carries a grid vertex and at most
// one nearby particle; the words of one vertex end with tlast. Every particle gets
// the kernel weight (1 - s^2)^3 with s = distance / kernel_radius, and the block
// accumulates the weight and the weighted particle position. On the last word it
// sends one result word: the distance from that word's vertex to the weighted mean
// position, minus particle_radius, in signed Q16.16 and saturated; a vertex with no
// weight gives 1.0 with the empty flag set. All arithmetic is fixed point.
// A front end classifies each word in the cycle it is accepted and places it in a
// four-word queue, so input words keep flowing while the back end is busy, until the
// queue is full. The back end shares one 32 by 32 multiplier over a sequencer. A word
// with no particle, a particle past the count limit or a particle with an axis
// distance at or beyond kernel_radius is passed over in the idle state. A particle
// inside that box but outside the kernel sphere gets zero weight, and one exactly on
// the vertex full weight, both without the division; any other particle runs the
// 16-step restoring division for 1 - s^2. The closing word of a vertex with weight
// runs a 64-step divider for the three mean coordinates, three squares and a 32-step
// square root. A finished result sits in an output register and the back end goes on
// with the next vertex until a second result would be ready. Configuration registers
// are to be written only while the block is idle; the block does not enforce this.
module particle_surface_scalar_field import psf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port.
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata,
	// Input words.
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// tdata from bit 0: vertex_x, vertex_y, vertex_z, particle_x, particle_y, particle_z
	input  logic [TDATA_W-1:0] s_axis_tdata,
	// tuser: has_particle
	input  logic               s_axis_tuser,
	input  logic               s_axis_tlast,
	// Result words.
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// tdata: scalar_value
	output logic [COORD_W-1:0] m_axis_tdata,
	// tuser: was_empty
	output logic               m_axis_tuser
);
	psf_cfg_t  cfg_q;
	psf_item_t front_item;
	psf_item_t queue_item;
	logic      push;
	logic      pop;
	logic      q_valid;
	logic      q_full;

	// Register file; both registers come out of reset at defaults: kernel_radius 1.0, particle_radius 0.5.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_radius   <= CFG_W'(ONE_Q);
			cfg_q.particle_radius <= CFG_W'(ONE_Q >> 1);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_KERNEL_RADIUS:   cfg_q.kernel_radius   <= cfg_wdata;
				REG_PARTICLE_RADIUS: cfg_q.particle_radius <= cfg_wdata;
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	psf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (push),
		.item          (front_item)
	);

	psf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (front_item),
		.pop      (pop),
		.valid    (q_valid),
		.item_out (queue_item),
		.full     (q_full)
	);

	psf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (queue_item),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata),
		.out_empty (m_axis_tuser)
	);
endmodule
